FILE: rtl/bdp_pkg.sv
// shared types and constants of the advertising data parser
`default_nettype none

package bdp_pkg;

    // largest payload that an ad structure may reach into
    localparam int unsigned MAX_ADV_BYTES = 31;

    localparam logic [7:0] POS_SAT = 8'd255;

    // ad structure type codes
    localparam logic [7:0] AD_FLAGS        = 8'h01;
    localparam logic [7:0] AD_UUID16_PART  = 8'h02;
    localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
    localparam logic [7:0] AD_UUID32_PART  = 8'h04;
    localparam logic [7:0] AD_UUID32_FULL  = 8'h05;
    localparam logic [7:0] AD_UUID128_PART = 8'h06;
    localparam logic [7:0] AD_UUID128_FULL = 8'h07;
    localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
    localparam logic [7:0] AD_NAME_FULL    = 8'h09;
    localparam logic [7:0] AD_TX_POWER     = 8'h0A;
    localparam logic [7:0] AD_APPEARANCE   = 8'h19;
    localparam logic [7:0] AD_MFR          = 8'hFF;

    // element sizes in bytes
    localparam logic [4:0] SIZE_PAIR    = 5'd2;
    localparam logic [4:0] SIZE_UUID32  = 5'd4;
    localparam logic [4:0] SIZE_UUID128 = 5'd16;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [3:0] {
        KIND_FLAGS    = 4'd0,
        KIND_UUID16   = 4'd1,
        KIND_UUID32   = 4'd2,
        KIND_UUID128  = 4'd3,
        KIND_NAME     = 4'd4,
        KIND_TX_POWER = 4'd5,
        KIND_APPEAR   = 4'd6,
        KIND_MFR_ID   = 4'd7,
        KIND_MFR_DATA = 4'd8,
        KIND_END      = 4'd9
    } kind_t;

    // work handed from the front to the back for one accepted byte
    typedef struct packed {
        logic        rec_valid;
        kind_t       kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        field_last;
        logic        end_mark;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bdp_in_if.sv
// request channel carrying payload bytes
`default_nettype none

interface bdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] adv_byte;
    logic       last_byte;

    modport source (output valid, output adv_byte, output last_byte, input ready);
    modport sink (input valid, input adv_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdp_out_if.sv
// request channel carrying decoded records
`default_nettype none

interface bdp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        field_last;
    logic        run_last;

    modport source (
        output valid, output kind, output value_low, output value_high,
        output field_last, output run_last, input ready
    );
    modport sink (
        input valid, input kind, input value_low, input value_high,
        input field_last, input run_last, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bdp_front.sv
// front end: walks ad structures and classifies each payload byte
`default_nettype none

module bdp_front import bdp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    bdp_in_if.sink adv,
    input  logic   push_ready,
    output logic   push,
    output cmd_t   cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  type_reg, type_next;
    logic [4:0]  count_reg, count_next;
    logic [63:0] asm_lo_reg, asm_lo_next;
    logic [63:0] asm_hi_reg, asm_hi_next;
    logic        ended_reg, ended_next;
    logic        taken_reg, taken_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  rem_dec;
    logic        fits;
    logic [8:0]  reach;
    logic [4:0]  cnt_inc;
    logic [63:0] merged_lo, merged_hi;

    logic        gather_en;
    logic [4:0]  gather_size;
    kind_t       gather_kind;
    logic        set_ended, set_taken;

    assign adv.ready = push_ready;
    assign accept    = adv.valid & push_ready;
    assign b         = adv.adv_byte;
    assign rem_dec   = remain_reg - 8'd1;
    assign cnt_inc   = count_reg + 5'd1;
    assign reach     = {1'b0, pos_reg} + 9'd1 + {1'b0, b};
    assign fits      = (b > 8'd1) && (reach <= 9'(MAX_ADV_BYTES));

    // drop the byte into its lane of the assembly
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            merged_lo[8*i +: 8] = asm_lo_reg[8*i +: 8]
                | ((count_reg[4:3] == 2'b00 && count_reg[2:0] == 3'(i)) ? b : 8'd0);
            merged_hi[8*i +: 8] = asm_hi_reg[8*i +: 8]
                | ((count_reg[4:3] == 2'b01 && count_reg[2:0] == 3'(i)) ? b : 8'd0);
        end
    end

    // parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (b == 8'd0)
                        phase_next = PH_LEN;
                    else if (fits)
                        phase_next = PH_TYPE;
                    else
                        phase_next = PH_SKIP;
                end
                PH_TYPE:
                    phase_next = (remain_reg != 8'd0) ? PH_DATA : PH_LEN;
                PH_DATA, PH_SKIP:
                    phase_next = (rem_dec == 8'd0) ? PH_LEN : phase_reg;
            endcase
            if (adv.last_byte)
                phase_next = PH_LEN;
        end
    end

    // which types gather multi-byte elements
    always_comb
    begin
        gather_en   = 1'b0;
        gather_size = SIZE_PAIR;
        gather_kind = KIND_UUID16;
        set_ended   = 1'b0;
        set_taken   = 1'b0;
        unique case (type_reg)
            AD_UUID16_PART, AD_UUID16_FULL:
                gather_en = 1'b1;
            AD_UUID32_PART, AD_UUID32_FULL:
            begin
                gather_en   = 1'b1;
                gather_size = SIZE_UUID32;
                gather_kind = KIND_UUID32;
            end
            AD_UUID128_PART, AD_UUID128_FULL:
            begin
                gather_en   = !taken_reg;
                gather_size = SIZE_UUID128;
                gather_kind = KIND_UUID128;
                set_taken   = 1'b1;
            end
            AD_APPEARANCE:
            begin
                gather_en   = !ended_reg;
                gather_kind = KIND_APPEAR;
                set_ended   = 1'b1;
            end
            AD_MFR:
            begin
                gather_en   = !ended_reg;
                gather_kind = KIND_MFR_ID;
                set_ended   = 1'b1;
            end
            default:
                gather_en = 1'b0;
        endcase
    end

    // state update and command
    always_comb
    begin
        pos_next    = pos_reg;
        remain_next = remain_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        asm_lo_next = asm_lo_reg;
        asm_hi_next = asm_hi_reg;
        ended_next  = ended_reg;
        taken_next  = taken_reg;

        cmd.rec_valid  = 1'b0;
        cmd.kind       = KIND_FLAGS;
        cmd.lo         = 64'd0;
        cmd.hi         = 64'd0;
        cmd.field_last = 1'b0;
        cmd.end_mark   = accept & adv.last_byte;

        if (accept)
        begin
            if (pos_reg != POS_SAT)
                pos_next = pos_reg + 8'd1;

            unique case (phase_reg)
                PH_LEN:
                begin
                    if (b != 8'd0)
                        remain_next = fits ? (b - 8'd1) : b;
                end
                PH_TYPE:
                begin
                    type_next   = b;
                    count_next  = 5'd0;
                    asm_lo_next = 64'd0;
                    asm_hi_next = 64'd0;
                    ended_next  = 1'b0;
                    taken_next  = 1'b0;
                end
                PH_DATA:
                begin
                    remain_next = rem_dec;
                    if (type_reg == AD_FLAGS || type_reg == AD_TX_POWER)
                    begin
                        if (!ended_reg)
                        begin
                            cmd.rec_valid = 1'b1;
                            cmd.kind = (type_reg == AD_FLAGS) ? KIND_FLAGS : KIND_TX_POWER;
                            cmd.lo = {56'd0, b};
                            ended_next = 1'b1;
                        end
                    end
                    else if (type_reg == AD_NAME_SHORT || type_reg == AD_NAME_FULL)
                    begin
                        if (!ended_reg)
                        begin
                            cmd.rec_valid  = 1'b1;
                            cmd.kind       = KIND_NAME;
                            cmd.lo         = {56'd0, b};
                            // an embedded zero closes the name early
                            cmd.field_last = (b == 8'd0) || (rem_dec == 8'd0);
                            ended_next     = (b == 8'd0);
                        end
                    end
                    else if (type_reg == AD_MFR && ended_reg)
                    begin
                        cmd.rec_valid  = 1'b1;
                        cmd.kind       = KIND_MFR_DATA;
                        cmd.lo         = {56'd0, b};
                        cmd.field_last = (rem_dec == 8'd0);
                    end
                    else if (gather_en)
                    begin
                        if (cnt_inc >= gather_size)
                        begin
                            cmd.rec_valid = 1'b1;
                            cmd.kind      = gather_kind;
                            cmd.lo        = merged_lo;
                            cmd.hi        = merged_hi;
                            asm_lo_next   = 64'd0;
                            asm_hi_next   = 64'd0;
                            count_next    = 5'd0;
                            ended_next    = ended_reg | set_ended;
                            taken_next    = taken_reg | set_taken;
                        end
                        else
                        begin
                            asm_lo_next = merged_lo;
                            asm_hi_next = merged_hi;
                            count_next  = cnt_inc;
                        end
                    end
                end
                PH_SKIP:
                    remain_next = rem_dec;
            endcase

            if (adv.last_byte)
            begin
                pos_next    = 8'd0;
                remain_next = 8'd0;
                type_next   = 8'd0;
                count_next  = 5'd0;
                asm_lo_next = 64'd0;
                asm_hi_next = 64'd0;
                ended_next  = 1'b0;
                taken_next  = 1'b0;
            end
        end
    end

    assign push = accept & (cmd.rec_valid | adv.last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            pos_reg    <= 8'd0;
            remain_reg <= 8'd0;
            type_reg   <= 8'd0;
            count_reg  <= 5'd0;
            asm_lo_reg <= 64'd0;
            asm_hi_reg <= 64'd0;
            ended_reg  <= 1'b0;
            taken_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
            asm_lo_reg <= asm_lo_next;
            asm_hi_reg <= asm_hi_next;
            ended_reg  <= ended_next;
            taken_reg  <= taken_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bdp_queue.sv
// short command queue between front and back
`default_nettype none

module bdp_queue import bdp_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic push_ready,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: rtl/bdp_back.sv
// back end: expands commands into records through an output register
`default_nettype none

module bdp_back import bdp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    bdp_out_if.source  rec
);

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    kind_t       kind_reg, kind_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] hi_reg, hi_next;
    logic        fl_reg, fl_next;
    logic        rl_reg, rl_next;
    logic        load_ok;

    assign load_ok = !valid_reg || rec.ready;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        fl_next    = fl_reg;
        rl_next    = rl_reg;
        pop        = 1'b0;
        if (load_ok)
        begin
            // end record owed from a byte whose data record went out first
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = KIND_END;
                lo_next    = 64'd0;
                hi_next    = 64'd0;
                fl_next    = 1'b0;
                rl_next    = 1'b1;
            end
            else if (head_valid)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (head.rec_valid)
                begin
                    kind_next = head.kind;
                    lo_next   = head.lo;
                    hi_next   = head.hi;
                    fl_next   = head.field_last;
                    rl_next   = !head.end_mark;
                    pend_next = head.end_mark;
                end
                else
                begin
                    kind_next = KIND_END;
                    lo_next   = 64'd0;
                    hi_next   = 64'd0;
                    fl_next   = 1'b0;
                    rl_next   = 1'b1;
                end
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        fl_reg   <= fl_next;
        rl_reg   <= rl_next;
    end

    assign rec.valid      = valid_reg;
    assign rec.kind       = kind_reg;
    assign rec.value_low  = lo_reg;
    assign rec.value_high = hi_reg;
    assign rec.field_last = fl_reg;
    assign rec.run_last   = rl_reg;

endmodule

`default_nettype wire

FILE: rtl/ble_adv_data_parser_top.sv
// top level of the advertising data parser: front, command queue and back
// the first record of a byte passes a queue slot, then the output register
// throughput: one payload byte per cycle while the queue has room; a byte giving
//   a data record and the end record fills the output register once per record
// reset: asynchronous, active low; parse state back to expecting a length byte,
//   queue emptied and output register invalid, no clearing pass
`default_nettype none

module ble_adv_data_parser_top import bdp_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    bdp_in_if.sink    adv,
    bdp_out_if.source rec
);

    // command from front to queue
    cmd_t front_cmd;
    logic front_push;
    logic queue_ready;

    // queue head to back
    cmd_t head_cmd;
    logic head_valid;
    logic back_pop;

    // front takes a byte whenever the queue has room, so it keeps going while
    // the back is stalled on the record port
    bdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .push_ready (queue_ready),
        .push       (front_push),
        .cmd        (front_cmd)
    );

    // decouples the parse from record delivery
    bdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_data  (front_cmd),
        .push_ready (queue_ready),
        .pop        (back_pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    // splits a command into one or two records, end record always last
    bdp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_cmd),
        .pop        (back_pop),
        .rec        (rec)
    );

endmodule

`default_nettype wire

FILE: test/bdp_checker.sv
// checker for the advertising data parser: predicts records per accepted byte and compares
`timescale 1ns / 1ps

module bdp_checker import bdp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bdp_in_if          adv,
    bdp_out_if         rec,
    output int         errors,
    output int         pending,
    output int         bytes_seen,
    output int         records_seen,
    output logic [9:0] kinds_seen
);

    typedef struct {
        kind_t       kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        field_last;
        logic        run_last;
    } record_t;

    // decoder state
    int unsigned at_pos;
    phase_t      phase;
    logic [7:0]  left;
    logic [7:0]  ad_type;
    logic [4:0]  elem_cnt;
    logic [63:0] acc_lo;
    logic [63:0] acc_hi;
    logic        field_done;
    logic        uuid_done;

    record_t     byte_recs[$];
    record_t     expected_recs[$];
    record_t     want;
    int          err_count;
    int          byte_count;
    int          rec_count;
    logic [9:0]  kinds;

    task automatic clear_decoder();
        at_pos     = 0;
        phase      = PH_LEN;
        left       = '0;
        ad_type    = '0;
        elem_cnt   = '0;
        acc_lo     = '0;
        acc_hi     = '0;
        field_done = 1'b0;
        uuid_done  = 1'b0;
    endtask

    task automatic add_record(input kind_t k, input logic [63:0] lo, input logic [63:0] hi,
                              input logic fl);
        record_t r;
        r.kind       = k;
        r.lo         = lo;
        r.hi         = hi;
        r.field_last = fl;
        r.run_last   = 1'b0;
        if (byte_recs.size() < 2)
            byte_recs.insert(byte_recs.size(), r);
    endtask

    // little-endian collection; true once the element is complete
    function automatic bit collect(input logic [7:0] b, input logic [4:0] size);
        int unsigned e;
        e = elem_cnt;
        if (e < 8)
            acc_lo |= 64'(b) << (8 * e);
        else if (e < 16)
            acc_hi |= 64'(b) << (8 * (e - 8));
        elem_cnt = 5'(e + 1);
        return elem_cnt >= size;
    endfunction

    task automatic take_element(input kind_t k);
        add_record(k, acc_lo, acc_hi, 1'b0);
        acc_lo   = '0;
        acc_hi   = '0;
        elem_cnt = '0;
    endtask

    task automatic decode_data(input logic [7:0] b, input logic closing);
        case (ad_type)
            AD_FLAGS, AD_TX_POWER:
                if (!field_done)
                begin
                    if (ad_type == AD_FLAGS)
                        add_record(KIND_FLAGS, 64'(b), '0, 1'b0);
                    else
                        add_record(KIND_TX_POWER, 64'(b), '0, 1'b0);
                    field_done = 1'b1;
                end
            AD_UUID16_PART, AD_UUID16_FULL:
                if (collect(b, SIZE_PAIR))
                    take_element(KIND_UUID16);
            AD_UUID32_PART, AD_UUID32_FULL:
                if (collect(b, SIZE_UUID32))
                    take_element(KIND_UUID32);
            AD_UUID128_PART, AD_UUID128_FULL:
                if (!uuid_done && collect(b, SIZE_UUID128))
                begin
                    take_element(KIND_UUID128);
                    uuid_done = 1'b1;
                end
            AD_NAME_SHORT, AD_NAME_FULL:
                if (!field_done)
                begin
                    if (b == 8'h00)
                    begin
                        add_record(KIND_NAME, '0, '0, 1'b1);
                        field_done = 1'b1;
                    end
                    else
                        add_record(KIND_NAME, 64'(b), '0, closing);
                end
            AD_APPEARANCE:
                if (!field_done && collect(b, SIZE_PAIR))
                begin
                    take_element(KIND_APPEAR);
                    field_done = 1'b1;
                end
            AD_MFR:
                if (field_done)
                    add_record(KIND_MFR_DATA, 64'(b), '0, closing);
                else if (collect(b, SIZE_PAIR))
                begin
                    take_element(KIND_MFR_ID);
                    field_done = 1'b1;
                end
            default:
                ;
        endcase
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic l);
        byte_recs.delete();
        case (phase)
            PH_LEN:
                if (b == 8'h00)
                    phase = PH_LEN;
                else if (b > 8'h01 && at_pos + 1 + b <= MAX_ADV_BYTES)
                begin
                    phase = PH_TYPE;
                    left  = b - 8'h01;
                end
                else
                begin
                    phase = PH_SKIP;
                    left  = b;
                end
            PH_TYPE:
            begin
                ad_type    = b;
                elem_cnt   = '0;
                acc_lo     = '0;
                acc_hi     = '0;
                field_done = 1'b0;
                uuid_done  = 1'b0;
                phase      = (left != 0) ? PH_DATA : PH_LEN;
            end
            PH_DATA:
            begin
                left = left - 8'h01;
                decode_data(b, left == 0);
                if (left == 0)
                    phase = PH_LEN;
            end
            default:
            begin
                left = left - 8'h01;
                if (left == 0)
                    phase = PH_LEN;
            end
        endcase
        if (at_pos < POS_SAT)
            at_pos++;
        if (l)
        begin
            // end record always closes the byte
            if (byte_recs.size() >= 2)
                void'(byte_recs.pop_back());
            add_record(KIND_END, '0, '0, 1'b0);
            clear_decoder();
        end
        if (byte_recs.size() > 0)
            byte_recs[byte_recs.size() - 1].run_last = 1'b1;
        foreach (byte_recs[i])
            expected_recs.insert(expected_recs.size(), byte_recs[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            expected_recs.delete();
            err_count  = 0;
            byte_count = 0;
            rec_count  = 0;
            kinds      = '0;
        end
        else
        begin
            if (rec.valid && rec.ready)
            begin
                rec_count++;
                if (rec.kind <= KIND_END)
                    kinds[rec.kind] = 1'b1;
                if (expected_recs.size() == 0)
                begin
                    $error("record of kind %0d with nothing expected", rec.kind);
                    err_count++;
                end
                else
                begin
                    want = expected_recs.pop_front();
                    if (rec.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, rec.kind);
                        err_count++;
                    end
                    if (rec.value_low !== want.lo)
                    begin
                        $error("value_low: expected %h, got %h", want.lo, rec.value_low);
                        err_count++;
                    end
                    if (rec.value_high !== want.hi)
                    begin
                        $error("value_high: expected %h, got %h", want.hi, rec.value_high);
                        err_count++;
                    end
                    if (rec.field_last !== want.field_last)
                    begin
                        $error("field_last: expected %0b, got %0b", want.field_last,
                               rec.field_last);
                        err_count++;
                    end
                    if (rec.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.run_last, rec.run_last);
                        err_count++;
                    end
                end
            end
            if (adv.valid && adv.ready)
            begin
                byte_count++;
                predict_byte(adv.adv_byte, adv.last_byte);
            end
        end
        errors       <= err_count;
        pending      <= expected_recs.size();
        bytes_seen   <= byte_count;
        records_seen <= rec_count;
        kinds_seen   <= kinds;
    end

endmodule

FILE: test/tb_ble_adv_data_parser_top.sv
// testbench top of the advertising data parser: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_ble_adv_data_parser_top import bdp_pkg::*;;

    // number of random payload bytes to aim for
    localparam int RANDOM_BYTES = 1150;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bdp_in_if  adv_ch ();
    bdp_out_if rec_ch ();

    // idling odds in percent, per cycle, for each side
    int tx_idle = 37;
    int rx_idle = 56;
    // asks the receiver for one long hold-off
    bit squeeze = 1'b0;

    int         fail_count;
    int         pending;
    int         bytes_seen;
    int         records_seen;
    logic [9:0] kinds_seen;

    int         sent;
    int         payloads;
    logic [7:0] pay[$];

    ble_adv_data_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv_ch),
        .rec   (rec_ch)
    );

    bdp_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv_ch),
        .rec          (rec_ch),
        .errors       (fail_count),
        .pending      (pending),
        .bytes_seen   (bytes_seen),
        .records_seen (records_seen),
        .kinds_seen   (kinds_seen)
    );

    always #6 clk = ~clk;

    // hard stop should the parser hang
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver side: random ready, plus one long hold-off counted here so the
    // queue inside the parser fills and its input stalls
    initial
    begin
        int  hold_left;
        bit  squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        rec_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                rec_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rec_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // one request on the byte channel; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < tx_idle)
        begin
            adv_ch.valid <= 1'b0;
            @(posedge clk);
        end
        adv_ch.valid     <= 1'b1;
        adv_ch.adv_byte  <= b;
        adv_ch.last_byte <= l;
        @(posedge clk);
        while (!adv_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // appends one byte to the payload buffer
    task automatic pay_add(input logic [7:0] v);
        pay.insert(pay.size(), v);
    endtask

    // the last byte of the buffer carries the end mark
    task automatic send_payload();
        for (int i = 0; i < pay.size(); i++)
            send_byte(pay[i], i == pay.size() - 1);
        payloads++;
    endtask

    // mostly known ad types, now and then an unknown one
    function automatic logic [7:0] pick_type();
        case ($urandom_range(13))
            0:       return AD_FLAGS;
            1:       return AD_UUID16_PART;
            2:       return AD_UUID16_FULL;
            3:       return AD_UUID32_PART;
            4:       return AD_UUID32_FULL;
            5:       return AD_UUID128_PART;
            6:       return AD_UUID128_FULL;
            7:       return AD_NAME_SHORT;
            8:       return AD_NAME_FULL;
            9:       return AD_TX_POWER;
            10:      return AD_APPEARANCE;
            11, 12:  return AD_MFR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // fills pay with one advertisement: mostly well-formed chains of ad
    // structures with random content, some noise, over-long and cut-short ones
    task automatic build_payload();
        int         style;
        int         limit;
        int         room;
        int         dlen;
        logic [7:0] t;
        pay.delete();
        style = $urandom_range(99);
        if (style < 10)
        begin
            repeat ($urandom_range(1, 40))
                pay_add(8'($urandom_range(255)));
        end
        else
        begin
            // a few run past the payload limit so late structures are skipped
            limit = (style < 15) ? 60 : MAX_ADV_BYTES;
            while (pay.size() < limit - 1 && $urandom_range(7) != 0)
            begin
                if ($urandom_range(19) == 0)
                begin
                    // zero length or length one, both skipped
                    pay_add(8'($urandom_range(1)));
                    continue;
                end
                t = pick_type();
                if (t == AD_UUID128_PART || t == AD_UUID128_FULL)
                    dlen = $urandom_range(13, 18);
                else
                    dlen = $urandom_range(0, 9);
                room = limit - pay.size() - 2;
                if (dlen > room && $urandom_range(3) != 0)
                    dlen = room;
                pay_add(8'(dlen + 1));
                pay_add(t);
                repeat (dlen)
                begin
                    if ((t == AD_NAME_SHORT || t == AD_NAME_FULL) && $urandom_range(5) == 0)
                        pay_add(8'h00);
                    else
                        pay_add(8'($urandom_range(255)));
                end
            end
            if (pay.size() == 0)
                pay_add(8'($urandom_range(255)));
            // payload cut off inside a structure
            if ($urandom_range(9) == 0 && pay.size() > 1)
                while (pay.size() > 1 && $urandom_range(3) != 0)
                    void'(pay.pop_back());
        end
    endtask

    initial
    begin
        bit long_done;
        long_done        = 1'b0;
        sent             = 0;
        payloads         = 0;
        adv_ch.valid     = 1'b0;
        adv_ch.adv_byte  = 8'h00;
        adv_ch.last_byte = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flags, uuid16, appearance, manufacturer id and one data byte that is
        // also the end of the payload
        pay = '{8'h02, AD_FLAGS, 8'h06,
                8'h03, AD_UUID16_FULL, 8'h0D, 8'h18,
                8'h03, AD_APPEARANCE, 8'hC1, 8'h03,
                8'h04, AD_MFR, 8'h34, 8'h12, 8'hAB};
        send_payload();
        // zero length, length one skip, uuid32, name cut by an embedded zero,
        // then a length byte of all ones that overruns the payload
        pay = '{8'h00, 8'h01, 8'h55,
                8'h05, AD_UUID32_FULL, 8'h78, 8'h56, 8'h34, 8'h12,
                8'h04, AD_NAME_FULL, 8'h41, 8'h00, 8'h42,
                8'hFF};
        send_payload();

        while (sent < RANDOM_BYTES)
        begin
            // idling schedule: sender light / receiver heavy, then swapped, then none
            if (sent < RANDOM_BYTES / 3)
            begin
                tx_idle = 37;
                rx_idle = 56;
            end
            else if (sent < 2 * RANDOM_BYTES / 3)
            begin
                tx_idle = 56;
                rx_idle = 37;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
                squeeze = 1'b1;
            end
            if (!long_done && sent > RANDOM_BYTES / 2)
            begin
                // position counter saturates; the final structure must be skipped
                long_done = 1'b1;
                pay.delete();
                repeat (256)
                    pay_add(8'h00);
                pay_add(8'h03);
                pay_add(AD_APPEARANCE);
                pay_add(8'h11);
                pay_add(8'h22);
            end
            else
                build_payload();
            send_payload();
        end
        adv_ch.valid <= 1'b0;

        // drain whatever records are still owed, then a short settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d payload bytes in %0d advertisements, %0d records checked",
                 bytes_seen, payloads, records_seen);
        $display("record kinds seen (end down to flags): %b", kinds_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
